// ===== sv/sgd_pkg.sv =====
// Shared constants and types of the Sobel gradient and direction block.
`default_nettype none
package sgd_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WEFF_W = COL_W + 1;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int WCMP_W = (WIDTH_REG_W > WEFF_W) ? WIDTH_REG_W : WEFF_W;
	localparam int ROW_W = 12;
	localparam int MIN_DIM = 3;
	localparam int HEIGHT_MAX = 4095;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

	localparam int PIX_W = 8;
	localparam int LINE_W = 2 * PIX_W;
	localparam int GRAD_W = 11;
	localparam int ROOT_W = 11;
	localparam int SQ_W = 2 * ROOT_W - 1;
	localparam int ROOT_STEPS = ROOT_W;
	localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1));

	localparam int PROD_W = 25;
	localparam logic signed [PROD_W-1:0] TAN_SCALE = 25'sd1000;
	localparam logic signed [PROD_W-1:0] TAN_HIGH = 25'sd2414;
	localparam logic signed [PROD_W-1:0] TAN_LOW = 25'sd414;

	localparam int SECTOR_W = 3;
	localparam logic [SECTOR_W-1:0] SECTOR_0 = 3'd0;
	localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
	localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
	localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
	localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
	localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
	localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;
	localparam logic [SECTOR_W-1:0] SECTOR_7 = 3'd7;

	typedef struct packed {
		logic signed [PROD_W-1:0] y_scaled;
		logic signed [PROD_W-1:0] x_high;
		logic signed [PROD_W-1:0] x_low;
	} tan_terms_t;

endpackage
`default_nettype wire

// ===== sv/sobel_gradient_direction.sv =====
// Top level: streaming 3x3 Sobel gradient, magnitude and direction.
//
// Pixels enter in raster order on the in channel (in_valid, in_stall, pixel).
// Frame size comes from the cfg port (cfg_we, cfg_index, cfg_data): register 0 is
// image_width, register 1 is image_height; write them only while the block is idle.
// Two previous rows live in one line RAM, one 16-bit entry per column, read when a
// pixel is taken and written back in the next cycle.
// Every interior pixel gives one item on the out channel: grad_x, grad_y, magnitude,
// sector and last_of_frame, describing the pixel one row up and one column left.
// Border pixels give no item.
// Flow: a border pixel passes through the line read only; an interior pixel also passes through
// gradient, multiply and the 11-step iterative square root, and its item is registered once the root is done.
// in_stall is high while a pixel is at work.
// The output register holds one finished item; while the receiver stalls, the next
// pixel is still taken and processed, and its item waits until the register frees.
// Reset clears counters, window and handshake state; sizes return to 640 x 480.
// Line RAM contents are undefined after reset; the first two rows of a frame fill it.
`default_nettype none
module sobel_gradient_direction (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sgd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sgd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sgd_pkg::PIX_W-1:0]           pixel,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [sgd_pkg::GRAD_W-1:0]        grad_x,
	output logic signed [sgd_pkg::GRAD_W-1:0]        grad_y,
	output logic        [sgd_pkg::ROOT_W-1:0]        magnitude,
	output logic        [sgd_pkg::SECTOR_W-1:0]      sector,
	output logic                                     last_of_frame
);

	typedef enum logic [5:0] {
		ST_IDLE       = 6'b000001,
		ST_READ       = 6'b000010,
		ST_GRAD       = 6'b000100,
		ST_MUL        = 6'b001000,
		ST_ROOT_START = 6'b010000,
		ST_ROOT       = 6'b100000
	} state_t;

	state_t state_q;

	logic [sgd_pkg::WIDTH_REG_W-1:0]  image_width_q;
	logic [sgd_pkg::HEIGHT_REG_W-1:0] image_height_q;
	logic [sgd_pkg::WCMP_W-1:0]       w_ext;
	logic [sgd_pkg::WEFF_W-1:0]       w_eff;
	logic [sgd_pkg::ROW_W-1:0]        h_eff;

	logic [sgd_pkg::COL_W-1:0] col_q;
	logic [sgd_pkg::ROW_W-1:0] row_q;
	logic                      accept;

	logic [sgd_pkg::COL_W-1:0] col_s1;
	logic [sgd_pkg::PIX_W-1:0] pix_s1;
	logic                      interior_s1;
	logic                      last_s1;

	logic [sgd_pkg::LINE_W-1:0] line_rdata;
	logic [sgd_pkg::PIX_W-1:0]  win_q [3][3];

	logic [sgd_pkg::GRAD_W-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [sgd_pkg::GRAD_W-1:0] gx_q, gy_q;
	logic signed [2*sgd_pkg::GRAD_W-1:0] sqx, sqy;
	logic [sgd_pkg::SQ_W-2:0]          sqx_q, sqy_q;
	sgd_pkg::tan_terms_t               terms_q;
	logic [sgd_pkg::SECTOR_W-1:0]      sector_comb;
	logic [sgd_pkg::SECTOR_W-1:0]      sector_s1;

	logic                         root_start;
	logic                         root_done;
	logic [sgd_pkg::SQ_W-1:0]     root_operand;
	logic [sgd_pkg::ROOT_W-1:0]   root;

	logic out_valid_q;
	logic out_free;
	logic load_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= sgd_pkg::IMAGE_WIDTH_RESET;
			image_height_q <= sgd_pkg::IMAGE_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sgd_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data[sgd_pkg::WIDTH_REG_W-1:0];
				sgd_pkg::REG_IMAGE_HEIGHT:
					image_height_q <= cfg_data[sgd_pkg::HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_ext = sgd_pkg::WCMP_W'(image_width_q);
		if (w_ext < sgd_pkg::WCMP_W'(sgd_pkg::MIN_DIM)) begin
			w_ext = sgd_pkg::WCMP_W'(sgd_pkg::MIN_DIM);
		end else if (w_ext > sgd_pkg::WCMP_W'(sgd_pkg::MAX_WIDTH)) begin
			w_ext = sgd_pkg::WCMP_W'(sgd_pkg::MAX_WIDTH);
		end
		w_eff = sgd_pkg::WEFF_W'(w_ext);
		if (image_height_q < sgd_pkg::HEIGHT_REG_W'(sgd_pkg::MIN_DIM)) begin
			h_eff = sgd_pkg::ROW_W'(sgd_pkg::MIN_DIM);
		end else begin
			h_eff = sgd_pkg::ROW_W'(image_height_q);
		end
	end

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign in_stall = (state_q != ST_IDLE);

	// frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if ((sgd_pkg::WEFF_W'(col_q) + sgd_pkg::WEFF_W'(1)) >= w_eff) begin
				col_q <= '0;
				if (((sgd_pkg::ROW_W+1)'(row_q) + (sgd_pkg::ROW_W+1)'(1))
						>= (sgd_pkg::ROW_W+1)'(h_eff)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + sgd_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + sgd_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			pix_s1 <= pixel;
			interior_s1 <= (row_q >= sgd_pkg::ROW_W'(2)) && (col_q >= sgd_pkg::COL_W'(2));
			last_s1 <= (row_q == h_eff - sgd_pkg::ROW_W'(1))
				&& (sgd_pkg::WEFF_W'(col_q) == w_eff - sgd_pkg::WEFF_W'(1));
		end
	end

	// line RAM: [15:8] row two above, [7:0] row one above
	sgd_ram #(
		.WIDTH(sgd_pkg::LINE_W),
		.DEPTH(sgd_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (col_s1),
		.wdata ({line_rdata[sgd_pkg::PIX_W-1:0], pix_s1}),
		.raddr (col_q),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (state_q == ST_READ) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= line_rdata[sgd_pkg::LINE_W-1:sgd_pkg::PIX_W];
			win_q[1][2] <= line_rdata[sgd_pkg::PIX_W-1:0];
			win_q[2][2] <= pix_s1;
		end
	end

	// gradients, squares and tangent products
	assign gx_pos = sgd_pkg::GRAD_W'(win_q[0][2]) + (sgd_pkg::GRAD_W'(win_q[1][2]) << 1)
		+ sgd_pkg::GRAD_W'(win_q[2][2]);
	assign gx_neg = sgd_pkg::GRAD_W'(win_q[0][0]) + (sgd_pkg::GRAD_W'(win_q[1][0]) << 1)
		+ sgd_pkg::GRAD_W'(win_q[2][0]);
	assign gy_pos = sgd_pkg::GRAD_W'(win_q[2][0]) + (sgd_pkg::GRAD_W'(win_q[2][1]) << 1)
		+ sgd_pkg::GRAD_W'(win_q[2][2]);
	assign gy_neg = sgd_pkg::GRAD_W'(win_q[0][0]) + (sgd_pkg::GRAD_W'(win_q[0][1]) << 1)
		+ sgd_pkg::GRAD_W'(win_q[0][2]);

	assign sqx = gx_q * gx_q;
	assign sqy = gy_q * gy_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_GRAD) begin
			gx_q <= $signed(gx_pos - gx_neg);
			gy_q <= $signed(gy_pos - gy_neg);
		end
		if (state_q == ST_MUL) begin
			sqx_q <= sqx[sgd_pkg::SQ_W-2:0];
			sqy_q <= sqy[sgd_pkg::SQ_W-2:0];
			terms_q.y_scaled <= sgd_pkg::PROD_W'(gy_q) * sgd_pkg::TAN_SCALE;
			terms_q.x_high <= sgd_pkg::PROD_W'(gx_q) * sgd_pkg::TAN_HIGH;
			terms_q.x_low <= sgd_pkg::PROD_W'(gx_q) * sgd_pkg::TAN_LOW;
		end
		if (state_q == ST_ROOT_START) begin
			sector_s1 <= sector_comb;
		end
	end

	sgd_sector u_sector (
		.grad_x (gx_q),
		.grad_y (gy_q),
		.terms  (terms_q),
		.sector (sector_comb)
	);

	assign root_start = (state_q == ST_ROOT_START);
	assign root_operand = sgd_pkg::SQ_W'(sqx_q) + sgd_pkg::SQ_W'(sqy_q);

	sgd_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (root_operand),
		.done    (root_done),
		.root    (root)
	);

	// sequencer
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_ROOT) && root_done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: state_q <= interior_s1 ? ST_GRAD : ST_IDLE;
				ST_GRAD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ROOT_START;
				ST_ROOT_START: state_q <= ST_ROOT;
				ST_ROOT: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			grad_x <= gx_q;
			grad_y <= gy_q;
			magnitude <= root;
			sector <= sector_s1;
			last_of_frame <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("taken pixel did not start a line read");

	a_read_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(in_valid && !in_stall))
		else $error("line read without a taken pixel");

	a_result_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ROOT && root_done))
		else $error("result shown before the square root finished");

	a_root_idle_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> root_done)
		else $error("square root busy while no pixel is at work");

endmodule
`default_nettype wire

// ===== sv/sgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/sgd_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module sgd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sgd_pkg::SQ_W-1:0]    operand,
	output logic                             done,
	output logic      [sgd_pkg::ROOT_W-1:0]  root
);

	localparam int RES_W = sgd_pkg::SQ_W + 1;

	logic                     busy_q;
	logic [sgd_pkg::SQ_W-1:0] v_q;
	logic [RES_W-1:0]         res_q;
	logic [sgd_pkg::SQ_W-1:0] bit_q;
	logic [RES_W-1:0]         trial;

	assign trial = res_q + RES_W'(bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= (bit_q >> 2) != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= operand;
			res_q <= '0;
			bit_q <= sgd_pkg::ROOT_BIT_INIT;
		end else if (busy_q) begin
			if (RES_W'(v_q) >= trial) begin
				v_q <= v_q - trial[sgd_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + RES_W'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = !busy_q;
	assign root = res_q[sgd_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/sgd_sector.sv =====
// Eight-sector direction code from exact cross-multiplied tangent tests.
`default_nettype none
module sgd_sector (
	input  wire logic signed [sgd_pkg::GRAD_W-1:0] grad_x,
	input  wire logic signed [sgd_pkg::GRAD_W-1:0] grad_y,
	input  wire sgd_pkg::tan_terms_t               terms,
	output logic             [sgd_pkg::SECTOR_W-1:0] sector
);

	logic signed [sgd_pkg::PROD_W-1:0] d_hm, d_hp, d_lm, d_lp;

	assign d_hm = terms.y_scaled - terms.x_high;
	assign d_hp = terms.y_scaled + terms.x_high;
	assign d_lm = terms.y_scaled - terms.x_low;
	assign d_lp = terms.y_scaled + terms.x_low;

	always_comb begin
		if (grad_x == '0) begin
			sector = grad_y[sgd_pkg::GRAD_W-1] ? sgd_pkg::SECTOR_2 : sgd_pkg::SECTOR_4;
		end else if (grad_x[sgd_pkg::GRAD_W-1]) begin
			if (grad_y[sgd_pkg::GRAD_W-1]) begin
				if (d_hm < 0) sector = sgd_pkg::SECTOR_0;
				else if (d_lm > 0) sector = sgd_pkg::SECTOR_6;
				else sector = sgd_pkg::SECTOR_7;
			end else begin
				if (d_hp > 0) sector = sgd_pkg::SECTOR_4;
				else if (d_lp > 0) sector = sgd_pkg::SECTOR_5;
				else sector = sgd_pkg::SECTOR_6;
			end
		end else begin
			if (grad_y[sgd_pkg::GRAD_W-1]) begin
				if (d_hp < 0) sector = sgd_pkg::SECTOR_0;
				else if (d_lp < 0) sector = sgd_pkg::SECTOR_1;
				else sector = sgd_pkg::SECTOR_2;
			end else begin
				if (d_lm < 0) sector = sgd_pkg::SECTOR_2;
				else if (d_hm < 0) sector = sgd_pkg::SECTOR_3;
				else sector = sgd_pkg::SECTOR_4;
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/sobel_gradient_direction_test.sv =====
// Self-checking testbench for the streaming Sobel gradient, magnitude and direction block.
`timescale 1ns / 1ps
module sobel_gradient_direction_test;
	import sgd_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
		logic [ROOT_W-1:0] magnitude;
		logic [SECTOR_W-1:0] sector;
		logic last_of_frame;
	} sobel_result_t;

	// one 3x3 frame, pixels in raster order from the top byte down
	typedef struct packed {
		logic [9*PIX_W-1:0] pixels;
		sobel_result_t result;
	} test_frame_t;

	typedef enum {STYLE_NOISE, STYLE_BINARY, STYLE_RAMP} pixel_style_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic [ROOT_W-1:0] magnitude;
	logic [SECTOR_W-1:0] sector;
	logic last_of_frame;

	sobel_gradient_direction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.grad_x(grad_x),
		.grad_y(grad_y),
		.magnitude(magnitude),
		.sector(sector),
		.last_of_frame(last_of_frame)
	);

	always #5 clk = ~clk;

	// shadow of the block
	logic [PIX_W-1:0] line_rows [2*MAX_WIDTH];
	logic [PIX_W-1:0] kernel [3][3];
	int col_pos = 0;
	int row_pos = 0;
	logic [WIDTH_REG_W-1:0] width_cfg = IMAGE_WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_cfg = IMAGE_HEIGHT_RESET;

	sobel_result_t pending_gradients[$];
	sobel_result_t table_result;
	bit table_pending = 1'b0;
	test_frame_t directed_frames [3];

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	bit hold_request = 1'b0;
	bit hold_armed = 1'b0;
	bit pressure_done = 1'b0;
	int hold_left = 0;
	int pixels_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	pixel_style_e frame_style = STYLE_NOISE;
	logic [PIX_W-1:0] frame_base = '0;

	function automatic int clamp_dim(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int floor_root(int v);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = 2047;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// sign of y/x - t/1000, x nonzero
	function automatic int slope_vs(int x, int y, int t);
		int d;
		d = int'(TAN_SCALE) * y - t * x;
		if (x < 0) d = -d;
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	function automatic logic [SECTOR_W-1:0] direction_code(int x, int y);
		int hi;
		int lo;
		hi = int'(TAN_HIGH);
		lo = int'(TAN_LOW);
		if (x == 0) return (y < 0) ? SECTOR_2 : SECTOR_4;
		if (x < 0 && y < 0) begin
			if (slope_vs(x, y, hi) > 0) return SECTOR_0;
			if (slope_vs(x, y, lo) < 0) return SECTOR_6;
			return SECTOR_7;
		end
		if (x < 0) begin
			if (slope_vs(x, y, -hi) < 0) return SECTOR_4;
			if (slope_vs(x, y, -lo) < 0) return SECTOR_5;
			return SECTOR_6;
		end
		if (y < 0) begin
			if (slope_vs(x, y, -hi) < 0) return SECTOR_0;
			if (slope_vs(x, y, -lo) < 0) return SECTOR_1;
			return SECTOR_2;
		end
		if (slope_vs(x, y, lo) < 0) return SECTOR_2;
		if (slope_vs(x, y, hi) < 0) return SECTOR_3;
		return SECTOR_4;
	endfunction

	function automatic int tap(int r, int c);
		return int'(kernel[r][c]);
	endfunction

	task automatic sobel_predict(input logic [PIX_W-1:0] p);
		int w;
		int h;
		int gx;
		int gy;
		int root;
		logic [PIX_W-1:0] above2;
		logic [PIX_W-1:0] above1;
		sobel_result_t r;
		w = clamp_dim(int'(width_cfg), MIN_DIM, MAX_WIDTH);
		h = clamp_dim(int'(height_cfg), MIN_DIM, HEIGHT_MAX);
		above2 = line_rows[col_pos];
		above1 = line_rows[MAX_WIDTH + col_pos];
		line_rows[col_pos] = above1;
		line_rows[MAX_WIDTH + col_pos] = p;
		for (int i = 0; i < 3; i++) begin
			kernel[i][0] = kernel[i][1];
			kernel[i][1] = kernel[i][2];
		end
		kernel[0][2] = above2;
		kernel[1][2] = above1;
		kernel[2][2] = p;
		if (row_pos >= 2 && col_pos >= 2) begin
			gx = (tap(0, 2) + 2 * tap(1, 2) + tap(2, 2)) - (tap(0, 0) + 2 * tap(1, 0) + tap(2, 0));
			gy = (tap(2, 0) + 2 * tap(2, 1) + tap(2, 2)) - (tap(0, 0) + 2 * tap(0, 1) + tap(0, 2));
			root = floor_root(gx * gx + gy * gy);
			r.grad_x = gx[GRAD_W-1:0];
			r.grad_y = gy[GRAD_W-1:0];
			r.magnitude = root[ROOT_W-1:0];
			r.sector = direction_code(gx, gy);
			r.last_of_frame = (row_pos == h - 1) && (col_pos == w - 1);
			if (table_pending) begin
				r = table_result;
				table_pending = 1'b0;
			end
			pending_gradients.push_back(r);
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) width_cfg = value[WIDTH_REG_W-1:0];
		else height_cfg = value[HEIGHT_REG_W-1:0];
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
		sobel_predict(value);
	endtask

	// border pixels give no item, so allow for one still in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_gradients.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		case (frame_style)
			STYLE_NOISE: return PIX_W'($urandom_range(255));
			STYLE_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return frame_base + PIX_W'($urandom_range(12));
		endcase
	endfunction

	// feeds pixels until the frame wraps; optionally resizes once partway through
	task automatic run_frame(input int split);
		int n;
		int w_eff;
		n = 0;
		do begin
			send_pixel(pick_pixel());
			n++;
			if (hold_armed && row_pos >= 2 && col_pos >= 2) begin
				hold_request = 1'b1;
				hold_armed = 1'b0;
			end
			if (n == split && (col_pos != 0 || row_pos != 0)) begin
				settle();
				w_eff = clamp_dim(int'(width_cfg), MIN_DIM, MAX_WIDTH);
				// only narrowing: wider rows would read line entries never written
				if (w_eff > MIN_DIM && $urandom_range(1))
					write_register(REG_IMAGE_WIDTH, $urandom_range(MIN_DIM, w_eff - 1));
				else
					write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
			end
		end while (col_pos != 0 || row_pos != 0);
	endtask

	task automatic random_frame();
		write_register(REG_IMAGE_WIDTH,
			($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(MIN_DIM, 16));
		write_register(REG_IMAGE_HEIGHT,
			($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(MIN_DIM, 8));
		frame_style = pixel_style_e'($urandom_range(2));
		frame_base = PIX_W'($urandom_range(255));
		run_frame(($urandom_range(3) == 0) ? $urandom_range(1, 40) : 0);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : output_check
		sobel_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_gradients.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				want = pending_gradients.pop_front();
				check_field("grad_x", int'(want.grad_x), int'(grad_x));
				check_field("grad_y", int'(want.grad_y), int'(grad_y));
				check_field("magnitude", int'(want.magnitude), int'(magnitude));
				check_field("sector", int'(want.sector), int'(sector));
				check_field("last_of_frame", int'(want.last_of_frame), int'(last_of_frame));
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		foreach (line_rows[i]) line_rows[i] = '0;
		foreach (kernel[i, j]) kernel[i][j] = '0;
		// all zero: flat, zero gradient points down the positive y side
		directed_frames[0] = '{72'h000000_000000_000000,
			'{11'sd0, 11'sd0, 11'd0, SECTOR_4, 1'b1}};
		// bright left column: strongest negative x gradient
		directed_frames[1] = '{72'hFF8000_FF8000_FF8000,
			'{-11'sd1020, 11'sd0, 11'd1020, SECTOR_6, 1'b1}};
		// bright top row: zero x with negative y
		directed_frames[2] = '{72'hFFFFFF_404040_000000,
			'{11'sd0, -11'sd1020, 11'd1020, SECTOR_2, 1'b1}};
		sender_idle_pct = 37;
		receiver_idle_pct = 56;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sizes below the minimum saturate to 3 x 3
		write_register(REG_IMAGE_WIDTH, 0);
		write_register(REG_IMAGE_HEIGHT, 1);
		foreach (directed_frames[f]) begin
			table_pending = 1'b1;
			table_result = directed_frames[f].result;
			for (int k = 0; k < 9; k++)
				send_pixel(directed_frames[f].pixels[9*PIX_W-1-PIX_W*k -: PIX_W]);
		end

		pixels_sent = 0;
		while (pixels_sent < RANDOM_ITEMS) begin
			if (pixels_sent >= 2 * RANDOM_ITEMS / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
				// long output hold-off while pixels keep coming
				if (!pressure_done) begin
					hold_armed = 1'b1;
					pressure_done = 1'b1;
				end
			end else if (pixels_sent >= RANDOM_ITEMS / 3) begin
				sender_idle_pct = 56;
				receiver_idle_pct = 37;
			end
			settle();
			random_frame();
		end

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
sv/sgd_pkg.sv
sv/sgd_ram.sv
sv/sgd_isqrt.sv
sv/sgd_sector.sv
sv/sobel_gradient_direction.sv
tb/sobel_gradient_direction_test.sv
